// ===== rtl/wsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Shared types and codes for the frame receiver and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned OPC_W  = 4;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd4096;

    // Seven-bit header length code that announces a 16-bit extended length.
    localparam logic [6:0] LEN7_EXT16 = 7'd126;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    localparam logic ERR_LEN64     = 1'b0;
    localparam logic ERR_TOO_LARGE = 1'b1;

    typedef enum logic [5:0] {
        PH_HDR0  = 6'b000001,
        PH_HDR1  = 6'b000010,
        PH_EXT16 = 6'b000100,
        PH_EXT64 = 6'b001000,
        PH_MASK  = 6'b010000,
        PH_DATA  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_out;
        logic [OPC_W-1:0]  opcode;
        logic              fin;
        logic              masked;
        logic [LEN_W-1:0]  payload_length;
        logic              error_code;
        logic              last;
    } result_t;

endpackage : wsfr_pkg

`default_nettype wire

// ===== rtl/websocket_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Parses the received byte stream into frame headers, unmasks payload bytes
// and reports empty frames and length errors.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------
//  in       | input     | in_valid/in_stall  | rx_byte
//  out      | output    | out_valid/out_stall| kind, data_out, opcode, fin,
//           |           |                    | masked, payload_length,
//           |           |                    | error_code, last
//  cfg      | input     | cfg_write_en       | cfg_write_data (max length)
//
// One byte is taken per cycle while the input does not stall. A byte is
// held in the input register; the header parser then updates its state and
// loads the result register, which drives the outputs.
// While downstream stalls and no result waits, bytes still pass through;
// the input stalls only when a result waits, a byte waits behind it and
// downstream stalls. Reset clears the parser and sets the length limit
// to 4096.
`default_nettype none

module websocket_frame_receiver_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [wsfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [wsfr_pkg::KIND_W-1:0]      kind,
    output logic [wsfr_pkg::BYTE_W-1:0]      data_out,
    output logic [wsfr_pkg::OPC_W-1:0]       opcode,
    output logic                             fin,
    output logic                             masked,
    output logic [wsfr_pkg::LEN_W-1:0]       payload_length,
    output logic                             error_code,
    output logic                             last,
    input  wire logic                        cfg_write_en,
    input  wire logic [wsfr_pkg::LEN_W-1:0]  cfg_write_data
);

    import wsfr_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    result_t           res_reg;
    result_t           res_next;
    logic              res_fire;
    logic              advance;

    logic [LEN_W-1:0]  max_len_reg;

    phase_t            phase_reg,   phase_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [LEN_W-1:0]  length_reg,  length_next;
    logic [LEN_W-1:0]  index_reg,   index_next;
    logic [KEY_W-1:0]  key_reg,     key_next;
    logic              fin_reg,     fin_next;
    logic [OPC_W-1:0]  opcode_reg,  opcode_next;
    logic              masked_reg,  masked_next;

    logic              len_done;
    logic [BYTE_W-1:0] key_byte;
    logic              data_last;
    logic [LEN_W:0]    index_plus;

    // The parser advances when it holds a byte and the result register is empty or drains now.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            max_len_reg <= cfg_write_data;
        end
    end

    assign index_plus = {1'b0, index_reg} + {{LEN_W{1'b0}}, 1'b1};

    always_comb
    begin
        unique case (index_reg[1:0])
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
        endcase
        if (!masked_reg)
        begin
            key_byte = '0;
        end
    end

    assign data_last = index_plus >= {1'b0, length_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        index_next  = index_reg;
        key_next    = key_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        len_done    = 1'b0;
        res_fire    = 1'b0;
        res_next    = '0;

        unique case (phase_reg)
            PH_HDR1:
            begin
                masked_next = in_byte_reg[7];
                key_next    = '0;
                count_next  = '0;
                if (in_byte_reg[6:0] < LEN7_EXT16)
                begin
                    length_next = {{(LEN_W-7){1'b0}}, in_byte_reg[6:0]};
                    len_done    = 1'b1;
                end
                else
                begin
                    length_next = '0;
                    phase_next  = (in_byte_reg[6:0] == LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
                end
            end
            PH_EXT16:
            begin
                length_next = {length_reg[7:0], in_byte_reg};
                count_next  = count_reg + 4'd1;
                len_done    = (count_next >= 4'd2);
            end
            PH_EXT64:
            begin
                count_next = count_reg + 4'd1;
                if (count_next >= 4'd8)
                begin
                    length_next         = '0;
                    res_fire            = 1'b1;
                    res_next.kind       = KIND_ERROR;
                    res_next.error_code = ERR_LEN64;
                    res_next.last       = 1'b1;
                    phase_next          = PH_HDR0;
                end
            end
            PH_MASK:
            begin
                key_next   = {key_reg[KEY_W-9:0], in_byte_reg};
                count_next = count_reg + 4'd1;
                if (count_next >= 4'd4)
                begin
                    index_next = '0;
                    if (length_reg == '0)
                    begin
                        res_fire      = 1'b1;
                        res_next.kind = KIND_EMPTY;
                        res_next.last = 1'b1;
                        phase_next    = PH_HDR0;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                res_fire                = 1'b1;
                res_next.kind           = KIND_BYTE;
                res_next.data_out       = in_byte_reg ^ key_byte;
                res_next.payload_length = length_reg;
                res_next.last           = data_last;
                index_next              = index_plus[LEN_W-1:0];
                if (data_last)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                // First header byte; illegal phase codes land here as well.
                fin_next    = in_byte_reg[7];
                opcode_next = in_byte_reg[3:0];
                masked_next = 1'b0;
                length_next = '0;
                index_next  = '0;
                count_next  = '0;
                phase_next  = PH_HDR1;
            end
        endcase

        // The frame length is now complete: check the limit, then choose
        // between the mask key, the payload and an empty frame.
        if (len_done)
        begin
            if (length_next > max_len_reg)
            begin
                res_fire                = 1'b1;
                res_next.kind           = KIND_ERROR;
                res_next.payload_length = length_next;
                res_next.error_code     = ERR_TOO_LARGE;
                res_next.last           = 1'b1;
                phase_next              = PH_HDR0;
            end
            else
            begin
                count_next = '0;
                index_next = '0;
                if (masked_next)
                begin
                    phase_next = PH_MASK;
                end
                else if (length_next == '0)
                begin
                    res_fire      = 1'b1;
                    res_next.kind = KIND_EMPTY;
                    res_next.last = 1'b1;
                    phase_next    = PH_HDR0;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
        end

        res_next.opcode = opcode_next;
        res_next.fin    = fin_next;
        res_next.masked = masked_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            count_reg  <= '0;
            length_reg <= '0;
            index_reg  <= '0;
            key_reg    <= '0;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            index_reg  <= index_next;
            key_reg    <= key_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_fire;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = res_reg.kind;
    assign data_out       = res_reg.data_out;
    assign opcode         = res_reg.opcode;
    assign fin            = res_reg.fin;
    assign masked         = res_reg.masked;
    assign payload_length = res_reg.payload_length;
    assign error_code     = res_reg.error_code;
    assign last           = res_reg.last;

endmodule : websocket_frame_receiver_unit

`default_nettype wire

// ===== rtl/wsfr_port_checker.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame receiver port checker
// Watches the result channel of the frame receiver for consistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_port_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [wsfr_pkg::KIND_W-1:0] kind,
    input wire logic [wsfr_pkg::BYTE_W-1:0] data_out,
    input wire logic [wsfr_pkg::LEN_W-1:0]  payload_length,
    input wire logic                        error_code,
    input wire logic                        last
);

    import wsfr_pkg::*;

    // A stalled transfer keeps its kind, data, payload length and last flag.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_out)
            && $stable(payload_length) && $stable(last))
        else $error("result changed while stalled");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_BYTE || kind == KIND_EMPTY || kind == KIND_ERROR))
        else $error("undefined result kind");

    // Only payload bytes carry data, the other results set last, and only errors carry an error code.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_BYTE |-> data_out == '0 && last)
        else $error("empty frame or error carries data or lacks last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERROR |-> error_code == 1'b0)
        else $error("error code set outside an error result");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EMPTY |-> payload_length == '0)
        else $error("empty frame reports nonzero length");

endmodule : wsfr_port_checker

bind websocket_frame_receiver_unit wsfr_port_checker u_wsfr_port_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data_out       (data_out),
    .payload_length (payload_length),
    .error_code     (error_code),
    .last           (last)
);

`default_nettype wire
